// File: rtl/ellpack_spmv_row_engine_defines.svh
// assertion macros used by the checker file
`ifndef ELLPACK_SPMV_ROW_ENGINE_DEFINES_SVH
`define ELLPACK_SPMV_ROW_ENGINE_DEFINES_SVH

// assertion that is switched off while reset is held
`define ESPV_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that is checked at every edge, reset included
`define ESPV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/espv_pkg.sv
// types and constants of the ellpack row engine
package espv_pkg;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    // register word index (paddr[2])
    localparam int  APB_AW              = 3;
    localparam logic REG_ENTRIES_PER_ROW = 1'b0;
    localparam logic REG_SKIP_MODE       = 1'b1;
    localparam logic [7:0] EPR_RESET     = 8'd1;

    // decoupling queue
    localparam int QUEUE_DEPTH = 4;

    // saturation limits
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] Y_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Y_MIN   = 32'sh8000_0000;

    // input beat
    typedef struct packed {
        logic               kind;
        logic [9:0]         index;
        logic               pad_marker;
        logic signed [31:0] elem_value;
        logic signed [31:0] y_in;
    } t_item;

    // result beat
    typedef struct packed {
        logic [19:0]        row_index;
        logic signed [31:0] y_out;
        logic               saturated;
    } t_res;

    // configuration seen by the front part
    typedef struct packed {
        logic [7:0] entries_per_row;
        logic       skip_mode;
    } t_cfg;

    // classified entry passed from front to back
    typedef struct packed {
        logic signed [31:0] elem_value;
        logic signed [31:0] x;
        logic signed [31:0] y_in;
        logic               first;
        logic               last;
        logic [19:0]        row_index;
    } t_op;

endpackage

// File: rtl/espv_ram.sv
// generic single write port ram with registered read
module espv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/espv_front.sv
// front part: takes beats, keeps the vector store and row position, classifies entries
module espv_front #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  espv_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  espv_pkg::t_item i_in,
    output logic           o_op_valid,
    input  logic           i_op_ready,
    output espv_pkg::t_op  o_op
);
    import espv_pkg::*;

    localparam int AW = $clog2(VECTOR_DEPTH);

    logic        accept;
    logic        is_load;
    logic        is_entry;
    logic        in_range;
    logic [7:0]  len;
    logic [8:0]  count;
    logic        last;
    logic        skip_now;
    logic [31:0] rdata;

    logic [7:0]  r_pos, n_pos;
    logic [19:0] r_row, n_row;
    logic        r_skipping, n_skipping;
    logic        r_s1_valid, n_s1_valid;

    // stage one payload
    logic signed [31:0] r_s1_elem;
    logic signed [31:0] r_s1_yin;
    logic               r_s1_first;
    logic               r_s1_last;
    logic [19:0]        r_s1_row;
    logic               r_s1_add;

    // handshake and classification
    assign o_in_ready = !r_s1_valid || i_op_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_load    = accept && (i_in.kind == KIND_LOAD);
    assign is_entry   = accept && (i_in.kind == KIND_ENTRY);
    assign in_range   = 32'(i_in.index) < VECTOR_DEPTH;

    // row end detection, zero length acts as one
    assign len      = (i_cfg.entries_per_row == 8'd0) ? 8'd1 : i_cfg.entries_per_row;
    assign count    = {1'b0, r_pos} + 9'd1;
    assign last     = count >= {1'b0, len};
    assign skip_now = r_skipping || (i_cfg.skip_mode && i_in.pad_marker);

    // vector store
    espv_ram #(
        .WIDTH (32),
        .DEPTH (VECTOR_DEPTH)
    ) u_vec (
        .i_clk   (i_clk),
        .i_we    (is_load && in_range),
        .i_waddr (AW'(i_in.index)),
        .i_wdata (i_in.elem_value),
        .i_re    (is_entry),
        .i_raddr (AW'(i_in.index)),
        .o_rdata (rdata)
    );

    // row position next state
    always_comb begin
        n_pos      = r_pos;
        n_row      = r_row;
        n_skipping = r_skipping;
        n_s1_valid = r_s1_valid;
        if (o_in_ready) begin
            n_s1_valid = is_entry;
        end
        if (is_load) begin
            n_pos      = 8'd0;
            n_row      = 20'd0;
            n_skipping = 1'b0;
        end else if (is_entry) begin
            if (last) begin
                n_pos      = 8'd0;
                n_row      = r_row + 20'd1;
                n_skipping = 1'b0;
            end else begin
                n_pos      = count[7:0];
                n_skipping = skip_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 8'd0;
            r_row      <= 20'd0;
            r_skipping <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pos      <= n_pos;
            r_row      <= n_row;
            r_skipping <= n_skipping;
            r_s1_valid <= n_s1_valid;
        end
    end

    // stage one payload, read data arrives alongside
    always_ff @(posedge i_clk) begin
        if (is_entry) begin
            r_s1_elem  <= i_in.elem_value;
            r_s1_yin   <= i_in.y_in;
            r_s1_first <= (r_pos == 8'd0);
            r_s1_last  <= last;
            r_s1_row   <= r_row;
            r_s1_add   <= in_range && !skip_now;
        end
    end

    // classified entry towards the queue
    assign o_op_valid      = r_s1_valid;
    assign o_op.elem_value = r_s1_elem;
    assign o_op.x          = r_s1_add ? rdata : 32'sd0;
    assign o_op.y_in       = r_s1_yin;
    assign o_op.first      = r_s1_first;
    assign o_op.last       = r_s1_last;
    assign o_op.row_index  = r_s1_row;

endmodule

// File: rtl/espv_queue.sv
// short first-in first-out queue between front and back
module espv_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  espv_pkg::t_op i_push,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output espv_pkg::t_op o_pop
);
    import espv_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_op           r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = r_cnt != CW'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop        = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointer and fill count update
    always_comb begin
        n_wr  = push ? PW'(r_wr + PW'(1)) : r_wr;
        n_rd  = pop  ? PW'(r_rd + PW'(1)) : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push;
        end
    end

endmodule

// File: rtl/espv_back.sv
// back part: multiply, saturating accumulate, final shift and output saturation
module espv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_op_valid,
    output logic           o_op_ready,
    input  espv_pkg::t_op  i_op,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output espv_pkg::t_res o_out
);
    import espv_pkg::*;

    logic en;

    // multiply stage
    logic               r_a_valid;
    logic signed [63:0] r_a_prod;
    logic               r_a_first;
    logic               r_a_last;
    logic signed [31:0] r_a_yin;
    logic [19:0]        r_a_row;

    // accumulator
    logic signed [63:0] r_sum, n_sum;
    logic               r_sat_seen, n_sat;
    logic signed [63:0] base;
    logic signed [63:0] sum_raw;
    logic               ovf;

    // finished row stage
    logic               r_f_valid;
    logic signed [63:0] r_f_sum;
    logic               r_f_sat;
    logic signed [31:0] r_f_yin;
    logic [19:0]        r_f_row;

    // output stage
    logic [48:0]        total;
    logic               osat;
    logic               r_out_valid;
    t_res               r_out;

    // the whole back part moves together when the output can take a beat
    assign en         = !r_out_valid || i_out_ready;
    assign o_op_ready = en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_f_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_a_valid   <= i_op_valid;
            r_f_valid   <= r_a_valid && r_a_last;
            r_out_valid <= r_f_valid;
        end
    end

    // product of matrix value and vector element
    always_ff @(posedge i_clk) begin
        if (en && i_op_valid) begin
            r_a_prod  <= i_op.elem_value * i_op.x;
            r_a_first <= i_op.first;
            r_a_last  <= i_op.last;
            r_a_yin   <= i_op.y_in;
            r_a_row   <= i_op.row_index;
        end
    end

    // saturating row sum, restarted on a row's first entry
    always_comb begin
        base    = r_a_first ? 64'sd0 : r_sum;
        sum_raw = base + r_a_prod;
        ovf     = (base[63] == r_a_prod[63]) && (sum_raw[63] != base[63]);
        n_sum   = ovf ? (r_a_prod[63] ? SUM_MIN : SUM_MAX) : sum_raw;
        n_sat   = (!r_a_first && r_sat_seen) || ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_seen <= 1'b0;
        end else if (en && r_a_valid) begin
            r_sat_seen <= n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_a_valid) begin
            r_sum   <= n_sum;
            r_f_sum <= n_sum;
            r_f_sat <= n_sat;
            r_f_yin <= r_a_yin;
            r_f_row <= r_a_row;
        end
    end

    // floor shift by 16, add y_in, saturate to 32 bits
    always_comb begin
        total = {{17{r_f_yin[31]}}, r_f_yin} + {r_f_sum[63], r_f_sum[63:16]};
        osat  = !((&total[48:31]) || (~|total[48:31]));
    end

    always_ff @(posedge i_clk) begin
        if (en && r_f_valid) begin
            r_out.row_index <= r_f_row;
            r_out.y_out     <= osat ? (total[48] ? Y_MIN : Y_MAX) : total[31:0];
            r_out.saturated <= r_f_sat || osat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/ellpack_spmv_row_engine.sv
// top level of the ellpack sparse matrix times vector row engine
//
// input channel (i_in_valid / o_in_ready / i_in): one beat per item. A load
// beat writes one vector element and restarts the row count at row zero; an
// entry beat brings a column and a value. After entries_per_row entries one
// result beat (o_out_valid / i_out_ready / o_out) carries the row index and
// y_in plus the row's dot product, saturated to 32 bits.
// throughput: one item per cycle while the receiver does not stall, set by
// the single vector store read port and the single multiply-accumulate unit.
// a row's last entry passes the store read, queue, multiply, accumulate and
// output registers in that order before it shows as a result.
// when the receiver stalls, the back part holds and a 4-deep queue keeps
// absorbing entries; the front keeps accepting until the queue fills.
// configuration: APB port, entries_per_row at 0x0, skip_mode at 0x4; write
// only while idle. pready is always high.
// reset (i_rst_n low, synchronous) empties the pipeline and queue, sets row
// and entry counts to zero, entries_per_row to 1, skip_mode to 0. The vector
// store is not cleared and must be loaded before use.
module ellpack_spmv_row_engine #(
    parameter int VECTOR_DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  espv_pkg::t_item               i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output espv_pkg::t_res                o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [espv_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import espv_pkg::*;

    logic [7:0] r_epr, n_epr;
    logic       r_skip, n_skip;
    logic       wr_en;
    t_cfg       cfg;
    logic       op_valid;
    logic       op_ready;
    t_op        op;
    logic       q_valid;
    logic       q_ready;
    t_op        q_op;

    // configuration registers
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        n_epr  = r_epr;
        n_skip = r_skip;
        if (wr_en) begin
            case (paddr[2])
                REG_ENTRIES_PER_ROW: n_epr  = pwdata[7:0];
                REG_SKIP_MODE:       n_skip = pwdata[0];
                default: begin
                    n_epr  = r_epr;
                    n_skip = r_skip;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epr  <= EPR_RESET;
            r_skip <= 1'b0;
        end else begin
            r_epr  <= n_epr;
            r_skip <= n_skip;
        end
    end

    // register readback
    always_comb begin
        case (paddr[2])
            REG_ENTRIES_PER_ROW: prdata = {24'd0, r_epr};
            REG_SKIP_MODE:       prdata = {31'd0, r_skip};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.entries_per_row = r_epr;
    assign cfg.skip_mode       = r_skip;

    // front part
    espv_front #(
        .VECTOR_DEPTH (VECTOR_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_op_valid (op_valid),
        .i_op_ready (op_ready),
        .o_op       (op)
    );

    // decoupling queue
    espv_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (op_valid),
        .o_push_ready (op_ready),
        .i_push       (op),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop        (q_op)
    );

    // back part
    espv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .o_op_ready  (q_ready),
        .i_op        (q_op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// File: rtl/espv_checker.sv
// port level checks of the row engine and their binding
`include "ellpack_spmv_row_engine_defines.svh"

module espv_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input espv_pkg::t_res              o_out,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [espv_pkg::APB_AW-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata
);
    import espv_pkg::*;

    // reset empties the output register
    `ESPV_ASSERT_ALWAYS(a_out_idle_after_reset, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // reset empties the front stage, so input is taken at once
    `ESPV_ASSERT_ALWAYS(a_in_ready_after_reset, i_clk, !i_rst_n |=> o_in_ready, "input not ready after reset")

    // a stalled result beat holds
    `ESPV_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out), "result beat changed while stalled")

    // row length readback matches the last write
    `ESPV_ASSERT_RST(a_epr_readback, i_clk, i_rst_n, (psel && penable && pwrite && paddr[2] == REG_ENTRIES_PER_ROW ##1 paddr[2] == REG_ENTRIES_PER_ROW) |-> prdata[7:0] == $past(pwdata[7:0]), "row length readback mismatch")

endmodule

bind ellpack_spmv_row_engine espv_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);

// File: test/testbench.sv
// self-checking testbench for the ellpack sparse matrix times vector row engine
`timescale 1ns / 100ps

module testbench;
    import espv_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;
    localparam int LIMIT_NS      = 1_000_000;
    localparam int PRINT_CAP     = 40;

    // kinds of row in the directed table
    typedef enum bit {STEP_BEAT, STEP_CFG} t_step_kind;

    typedef struct {
        t_step_kind  op;
        t_item       beat;
        logic        reg_sel;
        logic [7:0]  reg_val;
        bit          typed;
        t_res        want;
    } t_dir_step;

    // clock, reset and block ports
    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    t_item               in_beat   = '0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_res                out_beat;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [APB_AW-1:0]   paddr     = '0;
    logic [31:0]         pwdata    = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor copy of the vector store, row state and registers
    logic signed [31:0]  x_store [0:1023];
    bit                  x_written [0:1023];
    int unsigned         loaded_cols [$];
    longint              dot_acc;
    logic [7:0]          entry_idx;
    logic [19:0]         row_no;
    bit                  in_skip;
    bit                  acc_clipped;
    logic [7:0]          row_len_cfg;
    bit                  skip_cfg;

    // rows still owed by the block, oldest first
    t_res                pending_rows [$];
    t_res                oldest_row;
    t_dir_step           dir_steps [$];

    int                  mismatch_count = 0;
    int                  rows_checked   = 0;
    int                  sat_rows       = 0;
    int                  beats_sent     = 0;
    int                  loads_sent     = 0;
    int                  marker_beats   = 0;
    int                  cfg_writes     = 0;
    int                  burst_left     = 0;
    bit                  hold_off_req   = 1'b0;

    ellpack_spmv_row_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 clk = ~clk;

    // row result predictor: returns 1 when the beat closes a row
    function automatic bit predict_row_result(input t_item it, output t_res r);
        longint      prod;
        longint      sum;
        longint      total;
        int          cnt;
        int          len;
        r = '0;
        if (it.kind == KIND_LOAD) begin
            x_store[it.index] = it.elem_value;
            if (!x_written[it.index]) begin
                x_written[it.index] = 1'b1;
                loaded_cols.push_back(32'(it.index));
            end
            dot_acc     = 0;
            entry_idx   = '0;
            in_skip     = 1'b0;
            acc_clipped = 1'b0;
            row_no      = '0;
            return 1'b0;
        end
        if (skip_cfg && it.pad_marker) in_skip = 1'b1;
        if (!in_skip) begin
            prod = longint'($signed(it.elem_value)) * longint'($signed(x_store[it.index]));
            sum  = dot_acc + prod;
            // clip at the 64-bit limits on signed overflow
            if (dot_acc[63] == prod[63] && sum[63] != dot_acc[63]) begin
                sum = prod[63] ? SUM_MIN : SUM_MAX;
                acc_clipped = 1'b1;
            end
            dot_acc = sum;
        end
        cnt = int'(entry_idx) + 1;
        len = (row_len_cfg == 8'd0) ? 1 : int'(row_len_cfg);
        if (cnt < len) begin
            entry_idx = cnt[7:0];
            return 1'b0;
        end
        // floor shift back to q16.16, add y_in, clip to 32 bits
        total = longint'($signed(it.y_in)) + (dot_acc >>> 16);
        r.saturated = acc_clipped;
        if (total > longint'(Y_MAX)) begin
            total = longint'(Y_MAX);
            r.saturated = 1'b1;
        end
        if (total < longint'(Y_MIN)) begin
            total = longint'(Y_MIN);
            r.saturated = 1'b1;
        end
        r.row_index = row_no;
        r.y_out     = total[31:0];
        row_no      = row_no + 20'd1;
        dot_acc     = 0;
        entry_idx   = '0;
        in_skip     = 1'b0;
        acc_clipped = 1'b0;
        return 1'b1;
    endfunction

    // q16.16 value: mostly modest, sometimes full range or an extreme
    function automatic logic signed [31:0] pick_q16();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 15))
            0:       return Y_MAX;
            1:       return Y_MIN;
            2, 3:    return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    // random beat; a load with odds 1 in load_odds, never when load_odds is 0
    function automatic t_item random_beat(input int load_odds);
        t_item it;
        it = '0;
        it.pad_marker = ($urandom_range(0, 6) == 0);
        it.elem_value = pick_q16();
        it.y_in       = pick_q16();
        if (load_odds != 0 && $urandom_range(1, load_odds) == 1) begin
            it.kind  = KIND_LOAD;
            it.index = 10'($urandom_range(0, 1023));
            it.y_in  = $urandom;
        end else begin
            it.kind  = KIND_ENTRY;
            it.index = 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
        end
        return it;
    endfunction

    function automatic t_dir_step beat_step(input logic kind, input logic [9:0] col,
                                            input logic pad, input logic [31:0] val,
                                            input logic [31:0] yin);
        t_dir_step s;
        s.op              = STEP_BEAT;
        s.beat.kind       = kind;
        s.beat.index      = col;
        s.beat.pad_marker = pad;
        s.beat.elem_value = val;
        s.beat.y_in       = yin;
        s.reg_sel         = 1'b0;
        s.reg_val         = '0;
        s.typed           = 1'b0;
        s.want            = '0;
        return s;
    endfunction

    function automatic t_dir_step checked_step(input logic [9:0] col, input logic pad,
                                               input logic [31:0] val, input logic [31:0] yin,
                                               input logic [19:0] row, input logic [31:0] y,
                                               input logic sat);
        t_dir_step s;
        s                = beat_step(KIND_ENTRY, col, pad, val, yin);
        s.typed          = 1'b1;
        s.want.row_index = row;
        s.want.y_out     = y;
        s.want.saturated = sat;
        return s;
    endfunction

    function automatic t_dir_step cfg_step(input logic sel, input logic [7:0] val);
        t_dir_step s;
        s         = beat_step(KIND_LOAD, '0, 1'b0, '0, '0);
        s.op      = STEP_CFG;
        s.reg_sel = sel;
        s.reg_val = val;
        return s;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     rows_checked, what, got, want);
    endtask

    // sender pacing: bursts of random length with random gaps between them
    task automatic pace_sender();
        if (burst_left <= 0) begin
            if ($urandom_range(0, 4) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    // offer one beat, hold it until taken, then predict its row result
    task automatic send_beat(input t_item it, input bit typed, input t_res want);
        t_res calc;
        bit   has_row;
        in_valid <= 1'b1;
        in_beat  <= it;
        do @(posedge clk); while (!in_ready);
        has_row = predict_row_result(it, calc);
        if (typed) pending_rows.push_back(want);
        else if (has_row) pending_rows.push_back(calc);
        beats_sent++;
        if (it.kind == KIND_LOAD) loads_sent++;
        else if (it.pad_marker) marker_beats++;
    endtask

    // wait until every owed row is out and the pipeline has emptied
    task automatic drain_rows();
        in_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup then access, unused upper data bits random, then readback
    task automatic write_reg(input logic sel, input logic [7:0] val);
        logic [31:0] word;
        logic [31:0] want_rd;
        word = $urandom;
        if (sel == REG_ENTRIES_PER_ROW) begin
            word[7:0]   = val;
            row_len_cfg = val;
            want_rd     = {24'd0, val};
        end else begin
            word[0]  = val[0];
            skip_cfg = val[0];
            want_rd  = {31'd0, val[0]};
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (prdata !== want_rd)
            flag_mismatch("register readback", 64'(prdata), 64'(want_rd));
        cfg_writes++;
    endtask

    // one random phase at a given row length and skip setting
    task automatic run_phase(input logic [7:0] len, input bit skip, input int n_items,
                             input bit hold);
        t_item it;
        int    k;
        int    lead;
        drain_rows();
        write_reg(REG_ENTRIES_PER_ROW, len);
        write_reg(REG_SKIP_MODE, {7'd0, skip});
        lead = (loaded_cols.size() < 64) ? 40 : $urandom_range(0, 4);
        for (k = 0; k < n_items; k++) begin
            if (hold && k == 20) begin
                hold_off_req = 1'b1;
                burst_left   = 200;
            end
            // long rows get no stray loads so that they can complete
            it = random_beat(k < lead ? 1 : (len > 8'd16 ? 0 : 40));
            pace_sender();
            send_beat(it, 1'b0, '0);
        end
    endtask

    // result receiver: stalls on a mask pattern, long hold-off on request
    initial begin
        int unsigned cyc;
        int unsigned held;
        logic [7:0]  mask;
        cyc  = 0;
        mask = 8'hFF;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
            end else begin
                if (cyc % 48 == 0) begin
                    case ($urandom_range(0, 3))
                        0:       mask = 8'hFF;
                        1:       mask = 8'($urandom) | 8'h80;
                        2:       mask = 8'($urandom) | 8'h01;
                        default: mask = 8'hFE;
                    endcase
                end
                out_ready <= mask[cyc[2:0]];
                cyc++;
            end
        end
    end

    // result checker against the oldest owed row
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_rows.size() == 0) begin
                flag_mismatch("result with none owed, row_index",
                              64'(out_beat.row_index), '0);
            end else begin
                oldest_row = pending_rows.pop_front();
                if (out_beat.row_index !== oldest_row.row_index)
                    flag_mismatch("row_index", 64'(out_beat.row_index),
                                  64'(oldest_row.row_index));
                if (out_beat.y_out !== oldest_row.y_out)
                    flag_mismatch("y_out", 64'(out_beat.y_out), 64'(oldest_row.y_out));
                if (out_beat.saturated !== oldest_row.saturated)
                    flag_mismatch("saturated", 64'(out_beat.saturated),
                                  64'(oldest_row.saturated));
                rows_checked++;
                if (oldest_row.saturated) sat_rows++;
            end
        end
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // main sequence
    initial begin
        dot_acc     = 0;
        entry_idx   = '0;
        row_no      = '0;
        in_skip     = 1'b0;
        acc_clipped = 1'b0;
        row_len_cfg = EPR_RESET;
        skip_cfg    = 1'b0;
        foreach (x_written[i]) x_written[i] = 1'b0;

        // directed: loads at both ends of the store, extremes, floor rounding
        dir_steps.push_back(beat_step(KIND_LOAD, 10'd0, 1'b0, 32'h0001_0000, 32'h0));
        dir_steps.push_back(beat_step(KIND_LOAD, 10'd1023, 1'b0, 32'h7FFF_FFFF, 32'h0));
        dir_steps.push_back(beat_step(KIND_LOAD, 10'd1, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF));
        dir_steps.push_back(beat_step(KIND_LOAD, 10'd2, 1'b1, 32'h0000_0001, 32'h0));
        dir_steps.push_back(checked_step(10'd0, 1'b0, 32'h0002_0000, 32'h0001_0000,
                                         20'd0, 32'h0003_0000, 1'b0));
        dir_steps.push_back(checked_step(10'd1023, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                         20'd1, Y_MAX, 1'b1));
        dir_steps.push_back(checked_step(10'd1, 1'b0, 32'h8000_0000, 32'h0,
                                         20'd2, Y_MAX, 1'b1));
        dir_steps.push_back(checked_step(10'd1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
                                         20'd3, Y_MIN, 1'b1));
        // padding marker with skip mode off is an ordinary entry; -1 floors to -1
        dir_steps.push_back(checked_step(10'd2, 1'b1, 32'hFFFF_FFFF, 32'h0,
                                         20'd4, 32'hFFFF_FFFF, 1'b0));
        // a load restarts the row count
        dir_steps.push_back(beat_step(KIND_LOAD, 10'd3, 1'b0, 32'h0000_8000, 32'h0));
        dir_steps.push_back(checked_step(10'd3, 1'b0, 32'h0003_0000, 32'h0,
                                         20'd0, 32'h0001_8000, 1'b0));
        // two largest products clip the 64-bit row sum
        dir_steps.push_back(cfg_step(REG_ENTRIES_PER_ROW, 8'd2));
        dir_steps.push_back(beat_step(KIND_ENTRY, 10'd1, 1'b0, 32'h8000_0000, 32'h0));
        dir_steps.push_back(checked_step(10'd1, 1'b0, 32'h8000_0000, 32'h0,
                                         20'd1, Y_MAX, 1'b1));
        // skip mode: marker on the last entry, then marker early in the row
        dir_steps.push_back(cfg_step(REG_SKIP_MODE, 8'd1));
        dir_steps.push_back(beat_step(KIND_ENTRY, 10'd0, 1'b0, 32'h0001_0000, 32'h0));
        dir_steps.push_back(checked_step(10'd1023, 1'b1, 32'h7FFF_FFFF, 32'h0000_0005,
                                         20'd2, 32'h0001_0005, 1'b0));
        dir_steps.push_back(cfg_step(REG_ENTRIES_PER_ROW, 8'd3));
        dir_steps.push_back(beat_step(KIND_ENTRY, 10'd0, 1'b1, 32'h7FFF_FFFF, 32'h0));
        dir_steps.push_back(beat_step(KIND_ENTRY, 10'd1023, 1'b0, 32'h7FFF_FFFF, 32'h0));
        dir_steps.push_back(checked_step(10'd0, 1'b0, 32'h0000_1234, 32'h0000_0042,
                                         20'd3, 32'h0000_0042, 1'b0));
        // row length shrinks mid-row, zero length acts as one
        dir_steps.push_back(beat_step(KIND_ENTRY, 10'd0, 1'b0, 32'h0001_0000, 32'h0));
        dir_steps.push_back(cfg_step(REG_ENTRIES_PER_ROW, 8'd0));
        dir_steps.push_back(checked_step(10'd0, 1'b0, 32'h0001_0000, 32'h0,
                                         20'd4, 32'h0002_0000, 1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].op == STEP_CFG) begin
                drain_rows();
                write_reg(dir_steps[i].reg_sel, dir_steps[i].reg_val);
            end else begin
                pace_sender();
                send_beat(dir_steps[i].beat, dir_steps[i].typed, dir_steps[i].want);
            end
        end

        // random phases over row lengths and skip settings
        run_phase(8'd1,   1'b0, 150, 1'b1);
        run_phase(8'd2,   1'b1, 150, 1'b0);
        run_phase(8'd3,   1'b0, 150, 1'b0);
        run_phase(8'd5,   1'b1, 150, 1'b0);
        run_phase(8'd255, 1'b0, 300, 1'b0);
        run_phase(8'd8,   1'b1, 150, 1'b0);
        run_phase(8'd1,   1'b1, 150, 1'b1);
        run_phase(8'd255, 1'b1, 300, 1'b0);
        run_phase(8'd4,   1'b0, 150, 1'b0);
        run_phase(8'd16,  1'b1, 150, 1'b0);
        run_phase(8'd6,   1'b1, 100, 1'b0);
        drain_rows();

        $display("covered %0d beats: %0d vector loads, %0d entries with padding marker",
                 beats_sent, loads_sent, marker_beats);
        $display("%0d row results checked (%0d saturated) over %0d register writes",
                 rows_checked, sat_rows, cfg_writes);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/espv_pkg.sv
rtl/espv_ram.sv
rtl/espv_front.sv
rtl/espv_queue.sv
rtl/espv_back.sv
rtl/ellpack_spmv_row_engine.sv
rtl/espv_checker.sv
test/testbench.sv
